// ----- rtl/core/bf5_pkg.sv -----
// Shared types and constants of the 5x5 box filter.
package bf5_pkg;

   localparam int PIX_W      = 8;
   localparam int CHANNELS   = 3;
   localparam int PIXEL_W    = CHANNELS * PIX_W;
   localparam int ROW_W      = 12;
   localparam int OUT_COL_W  = 11;
   localparam int MAX_ROWS   = 4096;

   // CSR port
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 13;
   localparam int IMAGE_WIDTH_W  = 12;
   localparam int IMAGE_HEIGHT_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAY_MODE    = 2'd2;

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   // output queue
   localparam int OUTQ_DEPTH = 8;

   // per-item control carried alongside the datapath
   typedef struct packed {
      logic                 emit;
      logic                 last;
      logic                 gray;
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] col;
   } meta_type;

   // one result word
   typedef struct packed {
      logic [PIX_W-1:0]     c0;
      logic [PIX_W-1:0]     c1;
      logic [PIX_W-1:0]     c2;
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] col;
      logic                 last;
   } rsp_type;

endpackage

// ----- rtl/core/bf5_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
module bf5_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bf5_lane.sv -----
// One channel lane: window sum over two stages, then divide by the tap count.
module bf5_lane #(
   parameter int WINDOW = 5
) (
   input  logic                      clock,
   input  logic [bf5_pkg::PIX_W-1:0] win [WINDOW*WINDOW],
   output logic [bf5_pkg::PIX_W-1:0] mean
);

   import bf5_pkg::*;

   localparam int TAPS      = WINDOW * WINDOW;
   localparam int ROW_SUM_W = PIX_W + $clog2(WINDOW);
   localparam int SUM_W     = PIX_W + $clog2(TAPS);
   // floor(x/TAPS) == (x*DIV_MULT) >> DIV_SHIFT for every x below 2**SUM_W
   localparam int DIV_SHIFT = SUM_W + $clog2(TAPS);
   localparam int DIV_MULT  = (2 ** DIV_SHIFT + TAPS - 1) / TAPS;
   localparam int MULT_W    = SUM_W + 2;
   localparam int PROD_W    = SUM_W + MULT_W;

   logic [ROW_SUM_W-1:0] row_sum_in [WINDOW];
   logic [ROW_SUM_W-1:0] row_sum_ff [WINDOW];
   logic [SUM_W-1:0]     sum_in;
   logic [SUM_W-1:0]     sum_ff;
   logic [PROD_W-1:0]    prod;
   logic [PIX_W-1:0]     mean_ff;

   // stage 1: one sum per window row
   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         row_sum_in[i] = '0;
         for (int j = 0; j < WINDOW; j++) begin
            row_sum_in[i] = row_sum_in[i] + ROW_SUM_W'(win[i*WINDOW + j]);
         end
      end
   end

   // stage 2: total over rows
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < WINDOW; i++) begin
         sum_in = sum_in + SUM_W'(row_sum_ff[i]);
      end
   end

   // stage 3: reciprocal multiply
   assign prod = PROD_W'(sum_ff) * PROD_W'(DIV_MULT);

   always_ff @(posedge clock) begin
      row_sum_ff <= row_sum_in;
      sum_ff     <= sum_in;
      mean_ff    <= prod[DIV_SHIFT +: PIX_W];
   end

   assign mean = mean_ff;

endmodule

// ----- rtl/core/bf5_merge.sv -----
// Merge of lane means and control into result words, plus output queue.
module bf5_merge (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  bf5_pkg::meta_type         meta,
   input  logic [bf5_pkg::PIX_W-1:0] lane_mean [bf5_pkg::CHANNELS],
   input  logic                      reserve,
   output logic                      full,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output bf5_pkg::rsp_type          rsp
);

   import bf5_pkg::*;

   localparam int PTR_W = $clog2(OUTQ_DEPTH);
   localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

   rsp_type          queue_ff [OUTQ_DEPTH];
   rsp_type          word_in;
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] credit_ff;
   logic             pop;

   // gray mode zeroes the two color lanes
   always_comb begin
      word_in.c0   = lane_mean[0];
      word_in.c1   = meta.gray ? '0 : lane_mean[1];
      word_in.c2   = meta.gray ? '0 : lane_mean[2];
      word_in.row  = meta.row;
      word_in.col  = meta.col;
      word_in.last = meta.last;
   end

   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp       = queue_ff[rd_ptr_ff];
   // credits cover words already queued and words still in the pipe
   assign full      = (credit_ff == CNT_W'(OUTQ_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         credit_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff  <= count_ff + CNT_W'(push) - CNT_W'(pop);
         credit_ff <= credit_ff + CNT_W'(reserve) - CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= word_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != CNT_W'(OUTQ_DEPTH))
      else $error("output queue written while full");

   a_count_within_credit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= credit_ff)
      else $error("queued words exceed reserved credits");

endmodule

// ----- rtl/core/box_filter_5x5.sv -----
// Top level of the streaming 5x5 box (mean) filter.
//
// Usage:
//   req_* channel takes one pixel word per clock in raster order, three 8-bit
//   channels. A word is taken at an edge with req_valid high and req_stall low.
//   rsp_* channel returns one word per interior pixel: the per-channel mean of
//   the 5x5 window around the pixel two rows and two columns back, computed
//   as floor(sum/25), with its row, column and an end-of-frame flag. Border
//   pixels produce no word.
//   csr_* port sets image width, height and gray mode; write it only while
//   idle. A size write restarts the frame counters.
// Timing:
//   Throughput is one pixel per clock while req_stall is low, bounded by the
//   line stores: each does one read and one write per cycle. A result word
//   passes the input register, window, row sums, total, divide and queue
//   write before rsp_valid rises.
//   An 8-word output queue holds results while rsp_stall is high; req_stall
//   rises once 8 result words are owed, so no word is ever dropped.
// Reset:
//   Synchronous, clears counters, queue and pipe valids and loads 640x480
//   color mode. The line stores start at once with no clearing pass: rows of
//   a stale frame never reach a result.
module box_filter_5x5 #(
   parameter int MAX_WIDTH = 2048,
   parameter int WINDOW    = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   // pixel input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bf5_pkg::PIX_W-1:0]         req_pix_c0,
   input  logic [bf5_pkg::PIX_W-1:0]         req_pix_c1,
   input  logic [bf5_pkg::PIX_W-1:0]         req_pix_c2,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bf5_pkg::PIX_W-1:0]         rsp_out_c0,
   output logic [bf5_pkg::PIX_W-1:0]         rsp_out_c1,
   output logic [bf5_pkg::PIX_W-1:0]         rsp_out_c2,
   output logic [bf5_pkg::ROW_W-1:0]         rsp_out_row,
   output logic [bf5_pkg::OUT_COL_W-1:0]     rsp_out_col,
   output logic                              rsp_frame_last,
   // configuration
   input  logic                              csr_we,
   input  logic [bf5_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bf5_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import bf5_pkg::*;

   localparam int COL_W          = $clog2(MAX_WIDTH);
   localparam int LINES          = WINDOW - 1;
   localparam int MARGIN         = WINDOW - 1;          // first col/row with a full window
   localparam int CENTER_BACK    = WINDOW - 1 - WINDOW / 2;
   localparam int LANE_LAT       = 3;
   localparam int META_STAGES    = LANE_LAT + 1;
   localparam int RESET_LAST_COL = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH - 1 : RESET_WIDTH - 1;

   // ---------------- config and raster counters ----------------
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] last_col_ff;
   logic [ROW_W-1:0] last_row_ff;
   logic             gray_ff;
   logic [COL_W-1:0] last_col_in;
   logic [ROW_W-1:0] last_row_in;
   logic             accept;
   logic             emit;
   meta_type         meta_new;

   logic [IMAGE_WIDTH_W-1:0]  wr_width;
   logic [IMAGE_HEIGHT_W-1:0] wr_height;

   assign wr_width  = csr_wdata[IMAGE_WIDTH_W-1:0];
   assign wr_height = csr_wdata[IMAGE_HEIGHT_W-1:0];

   // clamp width to [1, MAX_WIDTH], height to [1, MAX_ROWS]; keep last index
   always_comb begin
      if (wr_width == '0) begin
         last_col_in = '0;
      end else if (32'(wr_width) > 32'(MAX_WIDTH)) begin
         last_col_in = COL_W'(MAX_WIDTH - 1);
      end else begin
         last_col_in = COL_W'(wr_width - 1'b1);
      end
      if (wr_height == '0) begin
         last_row_in = '0;
      end else if (32'(wr_height) > 32'(MAX_ROWS)) begin
         last_row_in = ROW_W'(MAX_ROWS - 1);
      end else begin
         last_row_in = ROW_W'(wr_height - 1'b1);
      end
   end

   assign accept = req_valid && !req_stall;
   assign emit   = (32'(col_ff) >= 32'(MARGIN)) && (32'(row_ff) >= 32'(MARGIN));

   always_comb begin
      meta_new.emit = emit;
      meta_new.last = (col_ff == last_col_ff) && (row_ff == last_row_ff);
      meta_new.gray = gray_ff;
      meta_new.row  = ROW_W'(32'(row_ff) - 32'(CENTER_BACK));
      meta_new.col  = OUT_COL_W'(32'(col_ff) - 32'(CENTER_BACK));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         last_col_ff <= COL_W'(RESET_LAST_COL);
         last_row_ff <= ROW_W'(RESET_HEIGHT - 1);
         gray_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               last_col_ff <= last_col_in;
               col_ff      <= '0;
               row_ff      <= '0;
            end
            CSR_IMAGE_HEIGHT: begin
               last_row_ff <= last_row_in;
               col_ff      <= '0;
               row_ff      <= '0;
            end
            CSR_GRAY_MODE: begin
               gray_ff <= csr_wdata[0];
            end
            default: ;
         endcase
      end else if (accept) begin
         if (col_ff == last_col_ff) begin
            col_ff <= '0;
            row_ff <= (row_ff == last_row_ff) ? '0 : row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // ---------------- stage 1: line store read ----------------
   logic               s1_valid_ff;
   logic [PIXEL_W-1:0] s1_px_ff;
   logic [COL_W-1:0]   s1_col_ff;
   meta_type           s1_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         // gray mode drops the color channels before they are stored
         s1_px_ff   <= {gray_ff ? PIX_W'(0) : req_pix_c2,
                        gray_ff ? PIX_W'(0) : req_pix_c1,
                        req_pix_c0};
         s1_col_ff  <= col_ff;
         s1_meta_ff <= meta_new;
      end
   end

   // line i holds the pixel from (WINDOW-1-i) rows above; the column shifts up
   logic [PIXEL_W-1:0] line_rd [LINES];
   logic [PIXEL_W-1:0] column [WINDOW];

   always_comb begin
      for (int i = 0; i < LINES; i++) begin
         column[i] = line_rd[i];
      end
      column[WINDOW-1] = s1_px_ff;
   end

   for (genvar i = 0; i < LINES; i++) begin : g_line
      bf5_ram #(
         .WIDTH (PIXEL_W),
         .DEPTH (MAX_WIDTH)
      ) u_line (
         .clock   (clock),
         .wr_en   (s1_valid_ff),
         .wr_addr (s1_col_ff),
         .wr_data (column[i+1]),
         .rd_en   (accept),
         .rd_addr (col_ff),
         .rd_data (line_rd[i])
      );
   end

   // ---------------- sliding window ----------------
   logic [PIXEL_W-1:0] window_ff [WINDOW][WINDOW];
   logic [PIX_W-1:0]   chan_win [CHANNELS][WINDOW*WINDOW];

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         for (int i = 0; i < WINDOW; i++) begin
            for (int j = 0; j < WINDOW - 1; j++) begin
               window_ff[i][j] <= window_ff[i][j+1];
            end
            window_ff[i][WINDOW-1] <= column[i];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < CHANNELS; k++) begin
         for (int i = 0; i < WINDOW; i++) begin
            for (int j = 0; j < WINDOW; j++) begin
               chan_win[k][i*WINDOW + j] = window_ff[i][j][k*PIX_W +: PIX_W];
            end
         end
      end
   end

   // ---------------- channel lanes ----------------
   logic [PIX_W-1:0] lane_mean [CHANNELS];

   for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
      bf5_lane #(
         .WINDOW (WINDOW)
      ) u_lane (
         .clock (clock),
         .win   (chan_win[k]),
         .mean  (lane_mean[k])
      );
   end

   // control rides along: window update plus the lane stages
   logic [META_STAGES-1:0] meta_valid_ff;
   meta_type               meta_ff [META_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_valid_ff <= '0;
      end else begin
         meta_valid_ff <= {meta_valid_ff[META_STAGES-2:0], s1_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      meta_ff[0] <= s1_meta_ff;
      for (int s = 1; s < META_STAGES; s++) begin
         meta_ff[s] <= meta_ff[s-1];
      end
   end

   // ---------------- merge and output queue ----------------
   rsp_type rsp_word;
   logic    queue_full;

   bf5_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .push      (meta_valid_ff[META_STAGES-1] && meta_ff[META_STAGES-1].emit),
      .meta      (meta_ff[META_STAGES-1]),
      .lane_mean (lane_mean),
      .reserve   (accept && emit),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp_word)
   );

   assign req_stall      = queue_full;
   assign rsp_out_c0     = rsp_word.c0;
   assign rsp_out_c1     = rsp_word.c1;
   assign rsp_out_c2     = rsp_word.c2;
   assign rsp_out_row    = rsp_word.row;
   assign rsp_out_col    = rsp_word.col;
   assign rsp_frame_last = rsp_word.last;

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_col_ff && row_ff <= last_row_ff)
      else $error("raster counter beyond frame size");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && !csr_we && meta_new.last |=> col_ff == '0 && row_ff == '0)
      else $error("counters did not wrap after the last pixel");

endmodule

// ----- bench/box_filter_5x5_mean_check.sv -----
`timescale 1ns / 1ps
// Scoreboard for the 5x5 box filter: tracks pixel, result and register ports, predicts and compares mean words.
module box_filter_5x5_mean_check (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [bf5_pkg::PIX_W-1:0]        req_pix_c0,
   input  logic [bf5_pkg::PIX_W-1:0]        req_pix_c1,
   input  logic [bf5_pkg::PIX_W-1:0]        req_pix_c2,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [bf5_pkg::PIX_W-1:0]        rsp_out_c0,
   input  logic [bf5_pkg::PIX_W-1:0]        rsp_out_c1,
   input  logic [bf5_pkg::PIX_W-1:0]        rsp_out_c2,
   input  logic [bf5_pkg::ROW_W-1:0]        rsp_out_row,
   input  logic [bf5_pkg::OUT_COL_W-1:0]    rsp_out_col,
   input  logic                             rsp_frame_last,
   input  logic                             csr_we,
   input  logic [bf5_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bf5_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                               owed,
   output int                               mismatches,
   output int                               words_checked
);

   import bf5_pkg::*;

   localparam int WINDOW   = 5;
   localparam int WIN_AREA = WINDOW * WINDOW;
   localparam int LINE_MAX = 2048;

   // filter state as the block should hold it
   logic [PIXEL_W-1:0]        line_buf [WINDOW-1][LINE_MAX];
   logic [PIXEL_W-1:0]        win      [WINDOW][WINDOW];
   int unsigned               col_pos;
   int unsigned               row_pos;
   logic [IMAGE_WIDTH_W-1:0]  cfg_w;
   logic [IMAGE_HEIGHT_W-1:0] cfg_h;
   logic                      cfg_gray;

   rsp_type mean_q [$];
   rsp_type want;
   rsp_type seen;
   int      bad;
   int      checked;

   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
      return (v == 0) ? 1 : ((v > hi) ? hi : v);
   endfunction

   // one accepted pixel: shift line buffers and window, queue a mean word if the window is full
   task automatic filter_pixel(input logic [PIX_W-1:0] p0, p1, p2);
      int unsigned        w;
      int unsigned        h;
      int unsigned        c;
      int unsigned        r;
      int unsigned        chan_sum [CHANNELS];
      logic [PIXEL_W-1:0] px;
      logic [PIXEL_W-1:0] col_in [WINDOW];
      rsp_type            m;
      w = clamp_size(cfg_w, LINE_MAX);
      h = clamp_size(cfg_h, MAX_ROWS);
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;
      px = cfg_gray ? {{(PIXEL_W - PIX_W){1'b0}}, p0} : {p2, p1, p0};

      for (int i = 0; i < WINDOW - 1; i++) col_in[i] = line_buf[i][c];
      col_in[WINDOW-1] = px;
      for (int i = 0; i < WINDOW - 1; i++) line_buf[i][c] = col_in[i+1];
      for (int i = 0; i < WINDOW; i++) begin
         for (int j = 0; j < WINDOW - 1; j++) win[i][j] = win[i][j+1];
         win[i][WINDOW-1] = col_in[i];
      end

      if (r >= WINDOW - 1 && c >= WINDOW - 1) begin
         for (int k = 0; k < CHANNELS; k++) chan_sum[k] = 0;
         for (int i = 0; i < WINDOW; i++)
            for (int j = 0; j < WINDOW; j++)
               for (int k = 0; k < CHANNELS; k++)
                  chan_sum[k] += win[i][j][PIX_W*k +: PIX_W];
         m.c0   = PIX_W'(chan_sum[0] / WIN_AREA);
         m.c1   = cfg_gray ? '0 : PIX_W'(chan_sum[1] / WIN_AREA);
         m.c2   = cfg_gray ? '0 : PIX_W'(chan_sum[2] / WIN_AREA);
         m.row  = ROW_W'(r - (WINDOW - 1) + WINDOW / 2);
         m.col  = OUT_COL_W'(c - (WINDOW - 1) + WINDOW / 2);
         m.last = (r == h - 1) && (c == w - 1);
         mean_q.push_back(m);
      end

      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   function automatic void compare_field(input string field, input int unsigned exp_v,
                                         input int unsigned got_v);
      if (exp_v != got_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
         bad++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (line_buf[i, j]) line_buf[i][j] = '0;
         foreach (win[i, j]) win[i][j] = '0;
         col_pos  = 0;
         row_pos  = 0;
         cfg_w    = IMAGE_WIDTH_W'(RESET_WIDTH);
         cfg_h    = IMAGE_HEIGHT_W'(RESET_HEIGHT);
         cfg_gray = 1'b0;
         mean_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH: begin
                  cfg_w   = csr_wdata[IMAGE_WIDTH_W-1:0];
                  col_pos = 0;
                  row_pos = 0;
               end
               CSR_IMAGE_HEIGHT: begin
                  cfg_h   = csr_wdata[IMAGE_HEIGHT_W-1:0];
                  col_pos = 0;
                  row_pos = 0;
               end
               CSR_GRAY_MODE: begin
                  cfg_gray = csr_wdata[0];
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall) filter_pixel(req_pix_c0, req_pix_c1, req_pix_c2);
         if (rsp_valid && !rsp_stall) begin
            seen.c0   = rsp_out_c0;
            seen.c1   = rsp_out_c1;
            seen.c2   = rsp_out_c2;
            seen.row  = rsp_out_row;
            seen.col  = rsp_out_col;
            seen.last = rsp_frame_last;
            if (mean_q.size() == 0) begin
               $display("%0t: result word with none expected, expected none, got row %0d col %0d",
                        $time, seen.row, seen.col);
               bad++;
            end else begin
               want = mean_q.pop_front();
               compare_field("out_c0", want.c0, seen.c0);
               compare_field("out_c1", want.c1, seen.c1);
               compare_field("out_c2", want.c2, seen.c2);
               compare_field("out_row", want.row, seen.row);
               compare_field("out_col", want.col, seen.col);
               compare_field("frame_last", want.last, seen.last);
               checked++;
            end
         end
      end
      owed          <= mean_q.size();
      mismatches    <= bad;
      words_checked <= checked;
   end

   initial begin
      bad     = 0;
      checked = 0;
   end

endmodule

// ----- bench/box_filter_5x5_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the 5x5 box filter: pixel stimulus, result idling, register loads and verdict.
module box_filter_5x5_tb;
   import bf5_pkg::*;

   localparam int LINE_MAX      = 2048;  // matches the block's MAX_WIDTH default
   localparam int SETTLE_CYCLES = 12;    // pipe depth plus margin
   localparam int LONG_HOLD     = 300;   // receiver back-pressure stretch, cycles
   localparam int RANDOM_PIXELS = 1200;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_valid  = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_pix_c0 = '0;
   logic [PIX_W-1:0]      req_pix_c1 = '0;
   logic [PIX_W-1:0]      req_pix_c2 = '0;
   logic                  rsp_valid;
   logic                  rsp_stall  = 1'b0;
   logic [PIX_W-1:0]      rsp_out_c0;
   logic [PIX_W-1:0]      rsp_out_c1;
   logic [PIX_W-1:0]      rsp_out_c2;
   logic [ROW_W-1:0]      rsp_out_row;
   logic [OUT_COL_W-1:0]  rsp_out_col;
   logic                  rsp_frame_last;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int owed;
   int mismatches;
   int words_checked;

   // shared idling controls
   bit no_idle   = 1'b0;   // both sides run without gaps
   bit want_hold = 1'b0;   // ask the receiver for one long stall
   bit hold_done = 1'b0;

   int          pixels_sent   = 0;
   int          settings_used = 0;
   int unsigned cur_w         = RESET_WIDTH;
   int unsigned cur_h         = RESET_HEIGHT;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   box_filter_5x5 dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pix_c0     (req_pix_c0),
      .req_pix_c1     (req_pix_c1),
      .req_pix_c2     (req_pix_c2),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_c0     (rsp_out_c0),
      .rsp_out_c1     (rsp_out_c1),
      .rsp_out_c2     (rsp_out_c2),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   box_filter_5x5_mean_check mean_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pix_c0     (req_pix_c0),
      .req_pix_c1     (req_pix_c1),
      .req_pix_c2     (req_pix_c2),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_c0     (rsp_out_c0),
      .rsp_out_c1     (rsp_out_c1),
      .rsp_out_c2     (rsp_out_c2),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .owed           (owed),
      .mismatches     (mismatches),
      .words_checked  (words_checked)
   );

   // Gap before a word: mostly none, now and then one of random length.
   function automatic int draw_gap();
      if (no_idle) return 0;
      if ($urandom_range(0, 2) == 0) return $urandom_range(0, 8);
      return 0;
   endfunction

   // Channel level, biased toward the rails.
   function automatic logic [PIX_W-1:0] draw_level();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
      return (v == 0) ? 1 : ((v > hi) ? hi : v);
   endfunction

   // Offer one pixel word; returns on the edge that takes it. Valid stays up
   // so a following word with no gap streams back to back.
   task automatic send_pixel(input logic [PIX_W-1:0] a, b, c);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_pix_c0 <= a;
      req_pix_c1 <= b;
      req_pix_c2 <= c;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
   endtask

   task automatic send_random(input int unsigned count);
      repeat (count) send_pixel(draw_level(), draw_level(), draw_level());
   endtask

   // Drop valid, wait for every owed word, then let the pipe settle since
   // border pixels may still be in flight without owing anything.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write per edge; the caller drops csr_we after the last one.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      if (idx == CSR_IMAGE_WIDTH) cur_w = value;
      else if (idx == CSR_IMAGE_HEIGHT) cur_h = value;
   endtask

   // Size writes restart the frame; a gray-only load lets the frame carry on.
   task automatic load_settings(input int unsigned w, h, input bit gray, input bit size_too);
      if (size_too) begin
         if ($urandom_range(0, 1)) begin
            write_reg(CSR_IMAGE_WIDTH, w);
            write_reg(CSR_IMAGE_HEIGHT, h);
         end else begin
            write_reg(CSR_IMAGE_HEIGHT, h);
            write_reg(CSR_IMAGE_WIDTH, w);
         end
      end
      write_reg(CSR_GRAY_MODE, gray);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Result side: a drawn stall before each word, and once a long hold that
   // lets the output queue fill and push back on the pixel side.
   initial begin : result_side
      int wait_cycles;
      forever begin
         if (want_hold && !hold_done) begin
            wait_cycles = LONG_HOLD;
            hold_done   = 1'b1;
         end else begin
            wait_cycles = draw_gap();
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      int unsigned w;
      int unsigned h;
      int unsigned ew;
      int unsigned eh;
      int unsigned n;
      int unsigned kind;
      int unsigned random_pixels;
      bit          gray;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings are 640x480: a few pixels stay on row 0, so no word.
      send_random(12);
      wait_idle();

      // One full-scale 5x5 frame: a single word of 255s, flagged frame end.
      load_settings(5, 5, 1'b0, 1'b1);
      repeat (25) send_pixel('1, '1, '1);
      wait_idle();

      // Back-pressure: receiver parks for a long stretch while pixels keep
      // streaming, so the queue fills and req_stall rises. Partway through
      // the frame the sender stops until every owed word is back.
      load_settings(8, 30, 1'b0, 1'b1);
      no_idle   <= 1'b1;
      want_hold <= 1'b1;
      send_random(90);
      wait_idle();
      send_random(60);
      wait_idle();
      no_idle <= 1'b0;

      // Random phases, mostly small frames; some undersized or clamped sizes,
      // gray flips mid-frame, and frames left partial then restarted.
      random_pixels = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         no_idle <= ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 9);
         gray = 1'($urandom_range(0, 1));
         if (kind <= 5) begin
            w = $urandom_range(5, 12);
            h = $urandom_range(5, 9);
            load_settings(w, h, gray, 1'b1);
         end else if (kind == 6) begin
            case ($urandom_range(0, 2))
               0: begin
                  w = $urandom_range(0, 4);
                  h = $urandom_range(5, 9);
               end
               1: begin
                  w = $urandom_range(5, 12);
                  h = $urandom_range(0, 4);
               end
               default: begin
                  w = $urandom_range(LINE_MAX + 1, 4095);
                  h = $urandom_range(5, 9);
               end
            endcase
            load_settings(w, h, gray, 1'b1);
         end else if (kind == 7) begin
            w = $urandom_range(13, 40);
            h = $urandom_range(5, 6);
            load_settings(w, h, gray, 1'b1);
         end else if (kind == 8) begin
            load_settings(cur_w, cur_h, gray, 1'b0);
         end
         // kind 9: no load, the frame picks up where it stopped

         ew = clamp_size(cur_w, LINE_MAX);
         eh = clamp_size(cur_h, MAX_ROWS);
         if (ew >= 5 && eh >= 5 && ew <= 64) begin
            n = $urandom_range(1, 2 * ew * eh);
         end else begin
            // sizes that can never fill a window here
            n = $urandom_range(1, 40);
         end
         if (n > RANDOM_PIXELS - random_pixels) n = RANDOM_PIXELS - random_pixels;
         random_pixels += n;
         send_random(n);
         wait_idle();
      end
      no_idle <= 1'b0;

      $display("run: %0d pixel words in, %0d mean words checked, %0d register loads",
               pixels_sent, words_checked, settings_used);
      $display("covered color and gray, gray flips mid-frame, undersized and clamped %s",
               "sizes, and long output back-pressure");
      if (mismatches == 0 && owed == 0) begin
         $display("box_filter_5x5_tb passed");
      end else begin
         $display("box_filter_5x5_tb failed");
      end
      $finish;
   end

   // Watchdog: many times the slowest legal run.
   initial begin
      #2_000_000;
      $display("box_filter_5x5_tb failed");
      $finish;
   end

endmodule
